// File: hw/rtl/cnhs_pkg.sv
package cnhs_pkg;

  localparam int unsigned TIMER_BITS  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SIG_FIRST   = 8'h4D;
  localparam logic [7:0] SIG_SECOND  = 8'h47;
  localparam logic [5:0] HDR_VERSION = 6'd1;
  localparam logic [10:0] CODE_BYTES = 11'd4;
  localparam logic [2:0] SEND_LEN_CODE = 3'd4;

  typedef enum logic [2:0] {
    REG_NEEDS_AUTH  = 3'd0,
    REG_AUTH_CODE   = 3'd1,
    REG_TIMEOUT_MS  = 3'd2,
    REG_NEG_KIND    = 3'd3,
    REG_KIND_COUNT  = 3'd4,
    REG_MAX_LENGTH  = 3'd5
  } reg_idx_e;

  localparam logic        RST_NEEDS_AUTH = 1'b0;
  localparam logic [31:0] RST_AUTH_CODE  = 32'd24;
  localparam logic [19:0] RST_TIMEOUT_MS = 20'd15000;
  localparam logic [2:0]  RST_NEG_KIND   = 3'd0;
  localparam logic [3:0]  RST_KIND_COUNT = 4'd2;
  localparam logic [10:0] RST_MAX_LENGTH = 11'd1200;

  typedef enum logic [2:0] {
    HDR_OK       = 3'd0,
    HDR_BAD_SIG  = 3'd1,
    HDR_BAD_VER  = 3'd2,
    HDR_BAD_KIND = 3'd3,
    HDR_TOO_LONG = 3'd4
  } hdr_status_e;

  typedef enum logic [1:0] {
    LINK_IDLE = 2'd0,
    LINK_NEG  = 2'd1,
    LINK_CONN = 2'd2
  } link_mode_e;

  typedef enum logic [2:0] {
    EV_TICK    = 3'd0,
    EV_HDR_ERR = 3'd1,
    EV_DATA    = 3'd2,
    EV_KEY_REJ = 3'd3,
    EV_NEG     = 3'd4
  } event_e;

  typedef struct packed {
    logic        needs_auth;
    logic [31:0] auth_code;
    logic [19:0] timeout_ms;
    logic [2:0]  neg_kind;
    logic [3:0]  kind_count;
    logic [10:0] max_length;
  } cfg_t;

  typedef struct packed {
    event_e      kind;
    hdr_status_e status;
    logic        has_code;
    logic [31:0] peer_code;
    logic [15:0] elapsed_ms;
  } event_t;

  typedef struct packed {
    logic        accepted;
    hdr_status_e header_status;
    link_mode_e  link_state;
    logic        send_request;
    logic [2:0]  send_length;
    logic [31:0] send_code;
  } result_t;

endpackage

// File: hw/rtl/cnhs_front.sv
module cnhs_front import cnhs_pkg::*; (
  input  cfg_t        cfg_i,
  input  logic        func_i,
  input  logic [7:0]  sig_first_i,
  input  logic [7:0]  sig_second_i,
  input  logic [5:0]  version_i,
  input  logic [2:0]  pkt_kind_i,
  input  logic [10:0] pkt_length_i,
  input  logic        key_ok_i,
  input  logic        code_present_i,
  input  logic [31:0] peer_code_i,
  input  logic [15:0] elapsed_ms_i,
  output event_t      event_o
);

  // Classify the header in check order; the back end sees only the outcome.
  always_comb begin
    event_o.status     = HDR_OK;
    event_o.has_code   = (pkt_length_i >= CODE_BYTES) && code_present_i;
    event_o.peer_code  = peer_code_i;
    event_o.elapsed_ms = elapsed_ms_i;
    event_o.kind       = EV_HDR_ERR;
    priority if (func_i) begin
      event_o.kind = EV_TICK;
    end else if (sig_first_i != SIG_FIRST || sig_second_i != SIG_SECOND) begin
      event_o.status = HDR_BAD_SIG;
    end else if (version_i != HDR_VERSION) begin
      event_o.status = HDR_BAD_VER;
    end else if ({1'b0, pkt_kind_i} >= cfg_i.kind_count) begin
      event_o.status = HDR_BAD_KIND;
    end else if (pkt_length_i > cfg_i.max_length) begin
      event_o.status = HDR_TOO_LONG;
    end else if (pkt_kind_i != cfg_i.neg_kind) begin
      event_o.kind = EV_DATA;
    end else if (!key_ok_i) begin
      event_o.kind = EV_KEY_REJ;
    end else begin
      event_o.kind = EV_NEG;
    end
  end

endmodule

// File: hw/rtl/cnhs_queue.sv
module cnhs_queue import cnhs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output event_t head_o
);

  event_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/cnhs_back.sv
module cnhs_back import cnhs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    empty_i,
  input  event_t  head_i,
  output logic    pop_o,
  output logic    res_valid_o,
  input  logic    res_stall_i,
  output result_t res_o
);

  link_mode_e              mode_q, mode_d;
  logic [TIMER_BITS-1:0]   timer_q, timer_d;
  logic [31:0]             learned_q, learned_d;
  logic                    res_valid_q;
  result_t                 res_q, res_d;

  logic [TIMER_BITS:0]     tmr_sum;
  logic [TIMER_BITS-1:0]   tmr_sat;
  logic [31:0]             send_code;
  logic                    res_free;

  assign res_free = !res_valid_q || !res_stall_i;
  assign pop_o    = !empty_i && res_free;

  always_comb begin
    tmr_sum = {1'b0, timer_q} + (TIMER_BITS + 1)'(head_i.elapsed_ms);
    tmr_sat = tmr_sum[TIMER_BITS] ? '1 : tmr_sum[TIMER_BITS-1:0];

    mode_d    = mode_q;
    timer_d   = timer_q;
    learned_d = learned_q;

    res_d               = '0;
    res_d.header_status = head_i.status;
    send_code           = cfg_i.needs_auth ? cfg_i.auth_code : learned_q;

    unique case (head_i.kind)
      EV_TICK: begin
        timer_d = tmr_sat;
        if (tmr_sat > TIMER_BITS'(cfg_i.timeout_ms)) begin
          mode_d = LINK_IDLE;
        end else if (mode_q == LINK_NEG) begin
          res_d.send_request = 1'b1;
        end
      end
      EV_HDR_ERR: begin
      end
      EV_DATA: begin
        timer_d        = '0;
        res_d.accepted = 1'b1;
      end
      EV_KEY_REJ: begin
        mode_d = LINK_IDLE;
      end
      EV_NEG: begin
        if (cfg_i.needs_auth) begin
          if (head_i.has_code) begin
            if (head_i.peer_code == cfg_i.auth_code) begin
              mode_d         = LINK_CONN;
              res_d.accepted = 1'b1;
            end else begin
              mode_d = LINK_IDLE;
            end
          end
        end else begin
          if (head_i.has_code) begin
            learned_d          = head_i.peer_code;
            mode_d             = LINK_CONN;
            send_code          = head_i.peer_code;
            res_d.send_request = 1'b1;
          end
          res_d.accepted = (mode_d != LINK_IDLE);
        end
      end
      default: begin
      end
    endcase

    if (res_d.send_request) begin
      res_d.send_code   = send_code;
      res_d.send_length = (send_code != '0) ? SEND_LEN_CODE : 3'd0;
    end
    res_d.link_state = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= LINK_NEG;
      timer_q     <= '0;
      learned_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q    <= mode_d;
        timer_q   <= timer_d;
        learned_q <= learned_d;
      end
      if (res_free) begin
        res_valid_q <= pop_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/connection_handshake_fsm.sv
// Link-setup state machine: idle, negotiating, connected.
// Input channel (in_valid_i / in_stall_o): one request per packet header
// (func_i = 0) or time tick (func_i = 1). A request is taken at a rising
// edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i): exactly one result per
// request, in order, taken when out_valid_o is high and out_stall_i low.
// Configuration channel (cfg_valid_i / cfg_ready_o): register index and
// data; write only while no request is in flight. cfg_ready_o is always high.
// A taken request passes through the classify queue and then the result
// register before its result shows.
// Throughput: one request per cycle while the output is not stalled; the
// back end's state update loop sets this. The queue holds two classified
// requests, so in_stall_o rises only after the output has been stalled.
// Reset: link negotiating, idle timer and learned code zero, registers at
// their reset values, queue and output empty.
// A stalled result holds its value until taken.
module connection_handshake_fsm import cnhs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  sig_first_i,
  input  logic [7:0]  sig_second_i,
  input  logic [5:0]  version_i,
  input  logic [2:0]  pkt_kind_i,
  input  logic [10:0] pkt_length_i,
  input  logic        key_ok_i,
  input  logic        code_present_i,
  input  logic [31:0] peer_code_i,
  input  logic [15:0] elapsed_ms_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [2:0]  header_status_o,
  output logic [1:0]  link_state_o,
  output logic        send_request_o,
  output logic [2:0]  send_length_o,
  output logic [31:0] send_code_o
);

  cfg_t    cfg_q;
  event_t  front_ev;
  event_t  head_ev;
  logic    q_full, q_empty, q_push, q_pop;
  result_t res;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.needs_auth <= RST_NEEDS_AUTH;
      cfg_q.auth_code  <= RST_AUTH_CODE;
      cfg_q.timeout_ms <= RST_TIMEOUT_MS;
      cfg_q.neg_kind   <= RST_NEG_KIND;
      cfg_q.kind_count <= RST_KIND_COUNT;
      cfg_q.max_length <= RST_MAX_LENGTH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_NEEDS_AUTH: cfg_q.needs_auth <= cfg_data_i[0];
        REG_AUTH_CODE:  cfg_q.auth_code  <= cfg_data_i;
        REG_TIMEOUT_MS: cfg_q.timeout_ms <= cfg_data_i[19:0];
        REG_NEG_KIND:   cfg_q.neg_kind   <= cfg_data_i[2:0];
        REG_KIND_COUNT: cfg_q.kind_count <= cfg_data_i[3:0];
        REG_MAX_LENGTH: cfg_q.max_length <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  // Front: check the header and reduce it to an event.
  cnhs_front u_front (
    .cfg_i          (cfg_q),
    .func_i         (func_i),
    .sig_first_i    (sig_first_i),
    .sig_second_i   (sig_second_i),
    .version_i      (version_i),
    .pkt_kind_i     (pkt_kind_i),
    .pkt_length_i   (pkt_length_i),
    .key_ok_i       (key_ok_i),
    .code_present_i (code_present_i),
    .peer_code_i    (peer_code_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .event_o        (front_ev)
  );

  // Hold events between front and back; stall the input only when full.
  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  cnhs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_ev),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_ev)
  );

  // Back: advance the link state and register the result.
  cnhs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .head_i      (head_ev),
    .pop_o       (q_pop),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign accepted_o      = res.accepted;
  assign header_status_o = res.header_status;
  assign link_state_o    = res.link_state;
  assign send_request_o  = res.send_request;
  assign send_length_o   = res.send_length;
  assign send_code_o     = res.send_code;

endmodule

// File: tb/connection_handshake_fsm_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the link-setup state machine. Drive header and tick
// requests through the valid/stall input channel, predict each result with a
// local copy of the link state and the register file, and compare every
// result field by field in order. Directed tests cover header errors, client
// and server negotiation, timeout and large timer steps. Random traffic then
// runs under several register settings and three idle/stall mixes.
module connection_handshake_fsm_tb;
  import cnhs_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI  = 3'd7;
  localparam logic [TIMER_BITS-1:0] TIMER_FULL = '1;
  localparam int unsigned RANDOM_BLOCKS = 5;

  // One request as the bench sees it; each member feeds one input port.
  typedef struct packed {
    logic        func;
    logic [7:0]  sig1;
    logic [7:0]  sig2;
    logic [5:0]  ver;
    logic [2:0]  kind;
    logic [10:0] len;
    logic        key_ok;
    logic        code_present;
    logic [31:0] peer_code;
    logic [15:0] elapsed;
  } link_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  link_req_t   drv_req;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic [2:0]  header_status;
  logic [1:0]  link_state;
  logic        send_req;
  logic [2:0]  send_length;
  logic [31:0] send_code;

  // Local copy of the block: registers, link mode, idle timer, learned code.
  cfg_t                  mdl_cfg;
  link_mode_e            mdl_link;
  logic [TIMER_BITS-1:0] mdl_timer;
  logic [31:0]           mdl_learned;

  result_t     predicted_replies[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always #10 clk = ~clk;

  connection_handshake_fsm DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (drv_req.func),
    .sig_first_i    (drv_req.sig1),
    .sig_second_i   (drv_req.sig2),
    .version_i      (drv_req.ver),
    .pkt_kind_i     (drv_req.kind),
    .pkt_length_i   (drv_req.len),
    .key_ok_i       (drv_req.key_ok),
    .code_present_i (drv_req.code_present),
    .peer_code_i    (drv_req.peer_code),
    .elapsed_ms_i   (drv_req.elapsed),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_o     (accepted),
    .header_status_o(header_status),
    .link_state_o   (link_state),
    .send_request_o (send_req),
    .send_length_o  (send_length),
    .send_code_o    (send_code)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Attach an outgoing negotiation packet: server sends its own code, client
  // echoes the code it learned. A zero code goes out with an empty payload.
  function automatic result_t with_send(result_t res);
    logic [31:0] code;
    code = mdl_cfg.needs_auth ? mdl_cfg.auth_code : mdl_learned;
    res.send_request = 1'b1;
    res.send_length  = (code != '0) ? SEND_LEN_CODE : 3'd0;
    res.send_code    = code;
    return res;
  endfunction

  // Advance the local link copy by one request and return the result it owes.
  function automatic result_t predict_link_step(link_req_t r);
    result_t               res;
    logic [TIMER_BITS:0]   sum;
    logic                  has_code;
    res = '0;
    res.header_status = HDR_OK;
    if (r.func) begin
      // Tick: saturate the timer, drop on timeout, else keep asking to negotiate.
      sum = {1'b0, mdl_timer} + (TIMER_BITS + 1)'(r.elapsed);
      mdl_timer = sum[TIMER_BITS] ? TIMER_FULL : sum[TIMER_BITS-1:0];
      if (mdl_timer > TIMER_BITS'(mdl_cfg.timeout_ms)) begin
        mdl_link = LINK_IDLE;
      end else if (mdl_link == LINK_NEG) begin
        res = with_send(res);
      end
    end else if (r.sig1 != SIG_FIRST || r.sig2 != SIG_SECOND) begin
      res.header_status = HDR_BAD_SIG;
    end else if (r.ver != HDR_VERSION) begin
      res.header_status = HDR_BAD_VER;
    end else if ({1'b0, r.kind} >= mdl_cfg.kind_count) begin
      res.header_status = HDR_BAD_KIND;
    end else if (r.len > mdl_cfg.max_length) begin
      res.header_status = HDR_TOO_LONG;
    end else if (r.kind != mdl_cfg.neg_kind) begin
      // Data packet: data traffic clears the idle timer.
      mdl_timer = '0;
      res.accepted = 1'b1;
    end else if (!r.key_ok) begin
      mdl_link = LINK_IDLE;
    end else begin
      has_code = (r.len >= CODE_BYTES) && r.code_present;
      if (mdl_cfg.needs_auth) begin
        // Server: no code leaves everything alone.
        if (has_code) begin
          if (r.peer_code == mdl_cfg.auth_code) begin
            mdl_link = LINK_CONN;
            res.accepted = 1'b1;
          end else begin
            mdl_link = LINK_IDLE;
          end
        end
      end else begin
        // Client: learn the code, connect (even from idle) and answer.
        if (has_code) begin
          mdl_learned = r.peer_code;
          mdl_link = LINK_CONN;
          res = with_send(res);
        end
        res.accepted = (mdl_link == LINK_NEG || mdl_link == LINK_CONN);
      end
    end
    res.link_state = mdl_link;
    return res;
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_NEEDS_AUTH: mdl_cfg.needs_auth = data[0];
      REG_AUTH_CODE:  mdl_cfg.auth_code  = data;
      REG_TIMEOUT_MS: mdl_cfg.timeout_ms = data[19:0];
      REG_NEG_KIND:   mdl_cfg.neg_kind   = data[2:0];
      REG_KIND_COUNT: mdl_cfg.kind_count = data[3:0];
      REG_MAX_LENGTH: mdl_cfg.max_length = data[10:0];
      default: ;  // spare indexes write nothing
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  // Sample both channels at the rising edge: predict each accepted request
  // first, then match each taken result against the oldest prediction.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) predicted_replies.push_back(predict_link_step(drv_req));
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none pending, expected nothing, actual state %0d",
                   $time, link_state);
        end else begin
          exp_r = predicted_replies.pop_front();
          check_field("accepted",      32'(exp_r.accepted),      32'(accepted));
          check_field("header_status", 32'(exp_r.header_status), 32'(header_status));
          check_field("link_state",    32'(exp_r.link_state),    32'(link_state));
          check_field("send_request",  32'(exp_r.send_request),  32'(send_req));
          check_field("send_length",   32'(exp_r.send_length),   32'(send_length));
          check_field("send_code",     exp_r.send_code,          send_code);
        end
      end
    end
  end

  // Receiver back-pressure: redraw the stall every falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  function automatic link_req_t junk_request();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(link_req_t)-1:0];
  endfunction

  // Well-formed header with random content in the fields it leaves open.
  function automatic link_req_t pkt_req(logic [2:0] kind, logic [10:0] len);
    link_req_t r;
    r = junk_request();
    r.func = 1'b0;
    r.sig1 = SIG_FIRST;
    r.sig2 = SIG_SECOND;
    r.ver  = HDR_VERSION;
    r.kind = kind;
    r.len  = len;
    r.key_ok = 1'b1;
    r.code_present = 1'b1;
    return r;
  endfunction

  function automatic link_req_t tick_req(logic [15:0] ms);
    link_req_t r;
    r = junk_request();
    r.func = 1'b1;
    r.elapsed = ms;
    return r;
  endfunction

  function automatic link_req_t neg_req(logic [10:0] len, logic present, logic [31:0] code);
    link_req_t r;
    r = pkt_req(mdl_cfg.neg_kind, len);
    r.code_present = present;
    r.peer_code = code;
    return r;
  endfunction

  // Mostly well-formed traffic so the link keeps moving between states;
  // the rest is headers with one defect and plain noise.
  function automatic link_req_t rand_request();
    link_req_t   r;
    int unsigned pick;
    int unsigned kinds;
    logic [10:0] len;
    kinds = (mdl_cfg.kind_count == 0) ? 1 :
            (mdl_cfg.kind_count > 8) ? 8 : 32'(mdl_cfg.kind_count);
    len = ($urandom_range(3) == 0) ? 11'($urandom_range(0, 7)) :
                                     11'($urandom_range(0, mdl_cfg.max_length));
    if (len > mdl_cfg.max_length) len = mdl_cfg.max_length;
    pick = $urandom_range(99);
    if (pick < 20) begin
      r = tick_req(16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 300)));
    end else if (pick < 55) begin
      r = neg_req(len, ($urandom_range(7) != 0), $urandom);
      r.key_ok = ($urandom_range(9) != 0);
      case ($urandom_range(3))
        0: r.peer_code = mdl_cfg.auth_code;
        1: r.peer_code = '0;
        default: ;
      endcase
    end else if (pick < 85) begin
      r = pkt_req(3'($urandom_range(0, kinds - 1)), len);
    end else if (pick < 95) begin
      r = pkt_req(3'($urandom_range(0, kinds - 1)), len);
      case ($urandom_range(4))
        0: r.sig1 = 8'($urandom);
        1: r.sig2 = 8'($urandom);
        2: r.ver  = 6'($urandom);
        3: r.kind = 3'($urandom_range(kinds - 1, 7));
        default: r.len = 11'($urandom_range(mdl_cfg.max_length, 2047));
      endcase
    end else begin
      r = junk_request();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one request; idle first with the sender's rate, each idle cycle
  // carrying junk, then hold the request until it is taken.
  task automatic send_request(link_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      drv_req  <= junk_request();
      @(negedge clk);
    end
    drv_req  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait out every pending result and the pipeline tail.
  task automatic drain_link();
    @(negedge clk);
    in_valid <= 1'b0;
    drv_req  <= junk_request();
    while (predicted_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write, only with the link drained.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    drain_link();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic randomize_config();
    logic [31:0] v;
    write_reg(REG_NEEDS_AUTH, $urandom);
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    write_reg(REG_AUTH_CODE, v);
    case ($urandom_range(5))
      0: v = 32'd1;
      1: v = 32'hF_FFFF;
      2: v = $urandom_range(0, 5);
      3: v = $urandom;
      default: v = $urandom_range(1, 2000);
    endcase
    write_reg(REG_TIMEOUT_MS, v);
    write_reg(REG_NEG_KIND, $urandom);
    v = ($urandom_range(7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    write_reg(REG_KIND_COUNT, v);
    case ($urandom_range(3))
      0: v = '0;
      1: v = 32'd2047;
      default: v = $urandom;
    endcase
    write_reg(REG_MAX_LENGTH, v);
    if ($urandom_range(3) == 0) write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Link starts negotiating: a tick asks to send, client with no code yet.
  task automatic test_reset_state();
    send_request(tick_req(16'd0));
    write_reg(REG_NEEDS_AUTH, 32'd1);
    send_request(tick_req(16'd1));          // server sends its reset code
    write_reg(REG_NEEDS_AUTH, 32'd0);
  endtask

  // Check the header checks and their priority; data packets pass.
  task automatic test_header_checks();
    link_req_t r;
    r = pkt_req(3'd7, 11'd2047);
    r.sig1 = 8'h00;
    r.ver  = 6'd0;
    send_request(r);                        // bad signature wins over all
    r = pkt_req(3'd1, 11'd0);
    r.sig2 = 8'hFF;
    send_request(r);
    r = pkt_req(3'd7, 11'd2047);
    r.ver = 6'd0;
    send_request(r);                        // bad version before bad type
    r.ver = 6'd63;
    send_request(r);
    send_request(pkt_req(3'd7, 11'd2047));  // bad type before too long
    send_request(pkt_req(3'd1, 11'd2047));
    send_request(pkt_req(3'd1, 11'd1200));  // length at the limit
    send_request(pkt_req(3'd1, 11'd0));
  endtask

  task automatic test_client_negotiation();
    link_req_t r;
    send_request(neg_req(11'd3, 1'b1, 32'hA5A5_A5A5));  // too short for a code
    send_request(neg_req(11'd4, 1'b0, 32'hA5A5_A5A5));  // code bytes missing
    r = neg_req(11'd8, 1'b1, 32'h1234_5678);
    r.key_ok = 1'b0;
    send_request(r);                                     // key rejected: drop
    send_request(neg_req(11'd2, 1'b1, 32'h1));           // no code while idle
    send_request(neg_req(11'd1200, 1'b1, 32'hFFFF_FFFF)); // connect from idle
    send_request(tick_req(16'd5));                       // connected: no send
    send_request(r);
    send_request(neg_req(11'd4, 1'b1, 32'h0));           // learn zero code
  endtask

  task automatic test_server_negotiation();
    write_reg(REG_NEEDS_AUTH, 32'd1);
    write_reg(REG_AUTH_CODE, 32'hFFFF_FFFF);
    send_request(neg_req(11'd3, 1'b1, 32'hFFFF_FFFF));   // no code: untouched
    send_request(neg_req(11'd4, 1'b1, 32'h0));           // wrong code: drop
    send_request(neg_req(11'd4, 1'b1, 32'hFFFF_FFFF));   // match: connect
    write_reg(REG_AUTH_CODE, 32'h0);
    send_request(neg_req(11'd100, 1'b1, 32'h0));
    write_reg(REG_NEEDS_AUTH, 32'd0);
  endtask

  // Drop only once the timer passes the limit; data clears the timer.
  task automatic test_idle_timeout();
    write_reg(REG_TIMEOUT_MS, 32'd100);
    send_request(pkt_req(3'd1, 11'd5));
    send_request(tick_req(16'd100));
    send_request(tick_req(16'd1));
    send_request(tick_req(16'd0));          // timer holds its value while idle
    send_request(pkt_req(3'd1, 11'd5));
    send_request(tick_req(16'd100));
    write_reg(REG_TIMEOUT_MS, 32'd1);
    send_request(tick_req(16'd2));
  endtask

  // Negotiation type at or above the type count never matches a header.
  task automatic test_negotiation_kind();
    write_reg(REG_NEG_KIND, 32'd5);
    write_reg(REG_KIND_COUNT, 32'd3);
    send_request(pkt_req(3'd5, 11'd10));
    send_request(pkt_req(3'd2, 11'd10));
    write_reg(REG_NEG_KIND, 32'd7);
    write_reg(REG_KIND_COUNT, 32'd8);
    send_request(neg_req(11'd4, 1'b1, 32'hC0DE_0001));
    write_reg(REG_MAX_LENGTH, 32'd0);
    send_request(pkt_req(3'd0, 11'd1));
    send_request(pkt_req(3'd0, 11'd0));
    write_reg(REG_NEG_KIND, {29'd0, RST_NEG_KIND});
    write_reg(REG_KIND_COUNT, {28'd0, RST_KIND_COUNT});
    write_reg(REG_MAX_LENGTH, {21'd0, RST_MAX_LENGTH});
  endtask

  // Spare indexes must not disturb any register.
  task automatic test_spare_registers();
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0);
    send_request(pkt_req(3'd1, 11'd1200));
    send_request(neg_req(11'd4, 1'b1, 32'h0000_0018));
  endtask

  // Walk the timer in full steps up to the largest timeout and one step
  // past it; no idling here.
  task automatic test_timer_limit();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_TIMEOUT_MS, 32'hFFFF_FFFF);   // upper bits masked off
    send_request(pkt_req(3'd1, 11'd0));
    repeat (17) send_request(tick_req(16'hFFFF));
    send_request(pkt_req(3'd1, 11'd0));
    send_request(tick_req(16'd0));
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned n_items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RANDOM_BLOCKS) begin
      randomize_config();
      repeat (n_items / RANDOM_BLOCKS) send_request(rand_request());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    drv_req   = '0;
    mdl_cfg   = '{needs_auth: RST_NEEDS_AUTH, auth_code: RST_AUTH_CODE,
                  timeout_ms: RST_TIMEOUT_MS, neg_kind: RST_NEG_KIND,
                  kind_count: RST_KIND_COUNT, max_length: RST_MAX_LENGTH};
    mdl_link    = LINK_NEG;
    mdl_timer   = '0;
    mdl_learned = '0;
    send_idle_pct  = 29;
    recv_stall_pct = 79;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_header_checks();
    test_client_negotiation();
    test_server_negotiation();
    test_idle_timeout();
    test_negotiation_kind();
    test_spare_registers();
    test_timer_limit();
    test_random_traffic(29, 79, 530);
    test_random_traffic(79, 29, 530);
    test_random_traffic(0, 0, 530);

    // Wait out every pending result before the verdict.
    drain_link();
    if (mismatch_count == 0) begin
      $display("** connection_handshake_fsm: PASSED **");
    end else begin
      $display("** connection_handshake_fsm: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("** connection_handshake_fsm: FAILED **");
    $finish;
  end

endmodule
